FILE: hw/rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the length-prefix deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  // Defaults and limits of the byte counts (both 1..4)
  localparam int unsigned MAGIC_LEN_DEF    = 4;
  localparam int unsigned HEADER_BYTES_DEF = 4;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CNT_W     = 2;   // counts up to four preamble or header bytes
  localparam int unsigned LEN_W     = 31;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_EN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_BIG_END  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME    = 2'd3;

  localparam logic [LEN_W-1:0] MAX_FRAME_RST = {LEN_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_MAGIC_BAD = 2'd2,
    KIND_LEN_BAD   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_last;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] magic_word;
    logic             magic_check_enable;
    logic             length_big_endian;
    logic [LEN_W-1:0] max_frame_length;
  } cfg_t;

endpackage

FILE: hw/rtl/lpd_if.sv
// ----------------------------------------------------------------------------
// lpd_if
// Valid/ready channels of the deframer: received bytes in, results out.
// ----------------------------------------------------------------------------
interface lpd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpd_res_if;
  logic              valid;
  logic              ready;
  lpd_pkg::kind_e    kind;
  logic [7:0]        payload_byte;
  logic              frame_last;

  modport source (output valid, output kind, output payload_byte, output frame_last,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte, input frame_last,
                  output ready);
endinterface

FILE: hw/rtl/lpd_parser.sv
// ----------------------------------------------------------------------------
// lpd_parser
// Preamble / header / payload sequencer; one byte per cycle, zero or one
// result per byte.
// ----------------------------------------------------------------------------
module lpd_parser #(
  parameter int unsigned MAGIC_LEN    = lpd_pkg::MAGIC_LEN_DEF,
  parameter int unsigned HEADER_BYTES = lpd_pkg::HEADER_BYTES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lpd_pkg::cfg_t             cfg_i,
  input  logic                      byte_valid_i,
  input  logic [lpd_pkg::BYTE_W-1:0] byte_i,
  output logic                      res_valid_o,
  output lpd_pkg::result_t          res_o
);
  import lpd_pkg::*;

  localparam int unsigned MAG_W = 8 * MAGIC_LEN;
  localparam int unsigned HDR_W = 8 * HEADER_BYTES;
  localparam logic [CNT_W-1:0] MAG_LAST = CNT_W'(MAGIC_LEN - 1);
  localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(HEADER_BYTES - 1);

  localparam logic [1:0] PH_MAGIC   = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic [1:0]       phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0] mag_q, mag_d;
  logic [HDR_W-1:0] hdr_q, hdr_d;
  logic [LEN_W-1:0] remain_q, remain_d;
  logic             halted_q, halted_d;

  logic [1:0]       phase_eff;
  logic [CNT_W-1:0] cnt_eff;
  logic [HDR_W-1:0] hdr_eff;
  logic [MAG_W-1:0] mag_next;
  logic [HDR_W-1:0] hdr_next;
  logic [31:0]      len32;
  logic             len_bad;

  always_comb begin
    // preamble check switched off: drop any partial preamble, start header
    phase_eff = phase_q;
    cnt_eff   = cnt_q;
    hdr_eff   = hdr_q;
    if (phase_q == PH_MAGIC && !cfg_i.magic_check_enable) begin
      phase_eff = PH_HEADER;
      cnt_eff   = '0;
      hdr_eff   = '0;
    end

    mag_next = MAG_W'({mag_q, byte_i});
    if (cfg_i.length_big_endian) begin
      hdr_next = HDR_W'({hdr_eff, byte_i});
    end else begin
      hdr_next = hdr_eff | (HDR_W'(byte_i) << {cnt_eff, 3'b000});
    end
    len32   = 32'(hdr_next);
    len_bad = hdr_next[HDR_W-1] || (len32 > {1'b0, cfg_i.max_frame_length});

    phase_d     = phase_q;
    cnt_d       = cnt_q;
    mag_d       = mag_q;
    hdr_d       = hdr_q;
    remain_d    = remain_q;
    halted_d    = halted_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_PAYLOAD, payload_byte: '0, frame_last: 1'b0};

    if (byte_valid_i && !halted_q) begin
      unique case (phase_eff)
        PH_MAGIC: begin
          mag_d = mag_next;
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == MAG_LAST) begin
            cnt_d = '0;
            mag_d = '0;
            if (mag_next != cfg_i.magic_word[MAG_W-1:0]) begin
              halted_d    = 1'b1;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_MAGIC_BAD;
            end else begin
              phase_d = PH_HEADER;
              hdr_d   = '0;
            end
          end
        end
        PH_PAYLOAD: begin
          res_valid_o        = 1'b1;
          res_o.payload_byte = byte_i;
          remain_d           = remain_q - 1'b1;
          if (remain_q <= LEN_W'(1)) begin
            res_o.frame_last = 1'b1;
            phase_d          = PH_HEADER;
            cnt_d            = '0;
          end
        end
        default: begin
          // header phase, also the unused code
          phase_d = PH_HEADER;
          hdr_d   = hdr_next;
          cnt_d   = cnt_eff + 1'b1;
          if (cnt_eff == HDR_LAST) begin
            cnt_d = '0;
            hdr_d = '0;
            if (len_bad) begin
              halted_d    = 1'b1;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_LEN_BAD;
            end else if (len32[LEN_W-1:0] == '0) begin
              res_valid_o      = 1'b1;
              res_o.kind       = KIND_EMPTY;
              res_o.frame_last = 1'b1;
            end else begin
              phase_d  = PH_PAYLOAD;
              remain_d = len32[LEN_W-1:0];
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC;
      cnt_q    <= '0;
      mag_q    <= '0;
      hdr_q    <= '0;
      remain_q <= '0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      mag_q    <= mag_d;
      hdr_q    <= hdr_d;
      remain_q <= remain_d;
      halted_q <= halted_d;
    end
  end

endmodule

FILE: hw/rtl/lpd_out_buf.sv
// ----------------------------------------------------------------------------
// lpd_out_buf
// Result register with a skid stage so the input side keeps flowing while
// a result waits.
// ----------------------------------------------------------------------------
module lpd_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  lpd_pkg::result_t in_data_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output lpd_pkg::result_t out_data_o,
  input  logic             out_ready_i
);
  import lpd_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = in_data_i;
        out_valid_d = in_valid_i;
      end
    end else if (in_valid_i && !skid_valid_q) begin
      skid_d       = in_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

FILE: hw/rtl/length_prefix_deframer_unit.sv
// ----------------------------------------------------------------------------
// length_prefix_deframer_unit
// Splits a byte stream into length-prefixed frames, optionally after
// checking a fixed preamble.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i   : one received byte per transaction (valid/ready).
//   res_o  : results; kind payload carries one payload byte with frame_last
//            on the frame's final byte, kind empty marks a zero-length frame,
//            kinds magic-mismatch and bad-length report an error, after which
//            the block swallows every byte without a result until reset.
//   cfg_*  : register writes (magic word, preamble enable, header byte
//            order, max frame length); write only while the block is idle.
// Throughput: one byte per cycle while rx_i.ready is high. Bytes of
//   preamble and header give no result, so the result stream has bubbles there.
// Output path: the result of an accepted byte is registered in the result
//   register, or in the skid stage while the result register waits on the sink.
// Stall: a result register plus a one-entry skid stage; rx_i.ready drops
//   only when both hold results, i.e. after the sink stalls for two
//   result-producing bytes in a row.
// Reset: asynchronous, active low; registers return to their defaults and
//   the sequencer restarts at the preamble (or the header if disabled).
// ----------------------------------------------------------------------------
module length_prefix_deframer_unit #(
  parameter int unsigned MAGIC_LEN    = lpd_pkg::MAGIC_LEN_DEF,
  parameter int unsigned HEADER_BYTES = lpd_pkg::HEADER_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lpd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lpd_pkg::CFG_W-1:0]     cfg_data_i,
  lpd_rx_if.sink                       rx_i,
  lpd_res_if.source                    res_o
);
  import lpd_pkg::*;

  cfg_t    cfg_q;
  logic    accept;
  logic    pr_valid;
  result_t pr_res;
  logic    buf_ready;
  result_t out_res;

  // Register file: written in place, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word         <= '0;
      cfg_q.magic_check_enable <= 1'b1;
      cfg_q.length_big_endian  <= 1'b1;
      cfg_q.max_frame_length   <= MAX_FRAME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAGIC_WORD:  cfg_q.magic_word         <= cfg_data_i;
        CFG_MAGIC_EN:    cfg_q.magic_check_enable <= cfg_data_i[0];
        CFG_LEN_BIG_END: cfg_q.length_big_endian  <= cfg_data_i[0];
        CFG_MAX_FRAME:   cfg_q.max_frame_length   <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign rx_i.ready = buf_ready;
  assign accept     = rx_i.valid && buf_ready;

  // Sequencer: state advances on every accepted byte until an error halts it
  lpd_parser #(
    .MAGIC_LEN    (MAGIC_LEN),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .byte_valid_i (accept),
    .byte_i       (rx_i.rx_byte),
    .res_valid_o  (pr_valid),
    .res_o        (pr_res)
  );

  // Result register and skid stage
  lpd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pr_valid),
    .in_data_i   (pr_res),
    .in_ready_o  (buf_ready),
    .out_valid_o (res_o.valid),
    .out_data_o  (out_res),
    .out_ready_i (res_o.ready)
  );

  assign res_o.kind         = out_res.kind;
  assign res_o.payload_byte = out_res.payload_byte;
  assign res_o.frame_last   = out_res.frame_last;

endmodule

FILE: hw/rtl/lpd_checker.sv
// ----------------------------------------------------------------------------
// lpd_checker
// Port-level checks of the deframer result channel.
// ----------------------------------------------------------------------------
module lpd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           res_valid_i,
  input logic           res_ready_i,
  input lpd_pkg::kind_e res_kind_i,
  input logic [7:0]     res_byte_i,
  input logic           res_last_i
);
  import lpd_pkg::*;

  logic err_seen_q;

  // an error result that was taken halts the block for good
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
    end else if (res_valid_i && res_ready_i &&
                 (res_kind_i == KIND_MAGIC_BAD || res_kind_i == KIND_LEN_BAD)) begin
      err_seen_q <= 1'b1;
    end
  end

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result valid dropped while stalled");

  a_no_result_after_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_seen_q |-> !res_valid_i)
    else $error("result after an error result");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_kind_i != KIND_PAYLOAD |-> res_byte_i == 8'd0)
    else $error("nonzero byte on a non-payload result");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_kind_i != KIND_PAYLOAD |->
      res_last_i == (res_kind_i == KIND_EMPTY))
    else $error("frame_last wrong for result kind");

endmodule

bind length_prefix_deframer_unit lpd_checker u_lpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_kind_i  (res_o.kind),
  .res_byte_i  (res_o.payload_byte),
  .res_last_i  (res_o.frame_last)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the length-prefix deframer: drives a byte stream
// (preamble, length headers, payload) under random stalls on both channels,
// predicts every result in-bench and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import lpd_pkg::*;

  localparam int unsigned PREAMBLE_LEN   = MAGIC_LEN_DEF;
  localparam int unsigned HDR_BYTES      = HEADER_BYTES_DEF;
  localparam int unsigned IDLE_PCT       = 23;    // stall rate on each side
  localparam int unsigned RANDOM_BYTES   = 1400;
  localparam int unsigned SEG_BYTES      = 200;   // bytes per register setting
  localparam int unsigned LATENCY_PAD    = 4;     // result reg + skid, rounded up
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transaction

  // Ways the single post-reset preamble check is exercised
  typedef enum logic [1:0] {
    PRE_MATCH,
    PRE_LATE_OFF,
    PRE_MISMATCH
  } preamble_mode_e;

  // Phases of the in-bench sequencer copy
  typedef enum logic [1:0] {
    SEQ_MAGIC   = 2'd0,
    SEQ_HEADER  = 2'd1,
    SEQ_PAYLOAD = 2'd2
  } seq_phase_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  lpd_rx_if  rx_if ();
  lpd_res_if res_if ();

  length_prefix_deframer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Register shadow: updated at the edge that writes the DUT register
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] shadow_magic    = '0;
  logic             shadow_magic_en = 1'b1;
  logic             shadow_big_end  = 1'b1;
  logic [LEN_W-1:0] shadow_max_len  = MAX_FRAME_RST;

  // --------------------------------------------------------------------------
  // Sequencer copy used for prediction, reset values
  // --------------------------------------------------------------------------
  seq_phase_e  seq_phase = SEQ_MAGIC;
  logic [30:0] seq_count = '0;   // bytes taken in the current phase
  logic [63:0] seq_shift = '0;   // preamble or header bytes gathered so far
  logic [30:0] seq_len   = '0;   // payload length of the current frame
  bit          seq_stuck = 1'b0; // set by either error, never cleared

  result_t     frame_results_due[$];   // expected results, oldest first

  int unsigned fail_count    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned bytes_sent    = 0;
  int unsigned src_idle_pct  = IDLE_PCT;
  int unsigned sink_idle_pct = IDLE_PCT;

  function automatic logic [63:0] byte_mask(int unsigned n);
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic void queue_result(kind_e k, logic [7:0] b, logic last);
    result_t r;
    r.kind         = k;
    r.payload_byte = b;
    r.frame_last   = last;
    frame_results_due.push_back(r);
  endfunction

  // Advance the sequencer copy by one accepted byte; queue the result, if any.
  function automatic void deframe_byte(logic [7:0] b);
    logic [63:0] hdr;
    logic        last;
    if (seq_stuck) return;  // halted: swallow silently

    // Preamble check turned off while still in the preamble: partial
    // preamble is dropped and this byte starts the header.
    if (seq_phase == SEQ_MAGIC && !shadow_magic_en) begin
      seq_phase = SEQ_HEADER;
      seq_count = '0;
      seq_shift = '0;
    end

    if (seq_phase == SEQ_MAGIC) begin
      seq_shift = ((seq_shift << 8) | {56'd0, b}) & byte_mask(PREAMBLE_LEN);
      seq_count = seq_count + 31'd1;
      if (seq_count < PREAMBLE_LEN) return;
      seq_count = '0;
      if (seq_shift != ({32'd0, shadow_magic} & byte_mask(PREAMBLE_LEN))) begin
        seq_shift = '0;
        seq_stuck = 1'b1;
        queue_result(KIND_MAGIC_BAD, 8'd0, 1'b0);
        return;
      end
      seq_shift = '0;
      seq_phase = SEQ_HEADER;
      return;
    end

    if (seq_phase == SEQ_PAYLOAD) begin
      seq_count = seq_count + 31'd1;
      last = (seq_count >= seq_len);
      if (last) begin
        seq_phase = SEQ_HEADER;
        seq_count = '0;
      end
      queue_result(KIND_PAYLOAD, b, last);
      return;
    end

    // Header phase; byte order sampled per byte
    seq_phase = SEQ_HEADER;
    if (shadow_big_end) seq_shift = (seq_shift << 8) | {56'd0, b};
    else seq_shift = seq_shift | ({56'd0, b} << (8 * seq_count[1:0]));
    seq_shift = seq_shift & byte_mask(HDR_BYTES);
    seq_count = seq_count + 31'd1;
    if (seq_count < HDR_BYTES) return;

    hdr       = seq_shift;
    seq_count = '0;
    seq_shift = '0;
    // Top header bit set means a negative length
    if (hdr[8*HDR_BYTES-1] || hdr > {33'd0, shadow_max_len}) begin
      seq_stuck = 1'b1;
      queue_result(KIND_LEN_BAD, 8'd0, 1'b0);
      return;
    end
    seq_len = hdr[30:0];
    if (seq_len == '0) queue_result(KIND_EMPTY, 8'd0, 1'b1);
    else seq_phase = SEQ_PAYLOAD;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predict on every input transaction, check every result
  // transaction against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      quiet_cycles++;
      if (rx_if.valid && rx_if.ready) begin
        deframe_byte(rx_if.rx_byte);
        quiet_cycles = 0;
      end
      if (res_if.valid && res_if.ready) begin
        quiet_cycles = 0;
        if (frame_results_due.size() == 0) begin
          $error("result with nothing expected: kind %0d byte %0h last %0b",
                 res_if.kind, res_if.payload_byte, res_if.frame_last);
          fail_count++;
        end else begin
          want = frame_results_due.pop_front();
          if (res_if.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, res_if.kind);
            fail_count++;
          end
          if (res_if.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, actual %0h",
                   want.payload_byte, res_if.payload_byte);
            fail_count++;
          end
          if (res_if.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0b, actual %0b",
                   want.frame_last, res_if.frame_last);
            fail_count++;
          end
        end
      end
    end
  end

  // Result sink back-pressure
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Watchdog: nothing moved on either channel for too long
  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // One byte transaction, with random source idling ahead of it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    bytes_sent++;
  endtask

  // Length header in the byte order currently programmed
  task automatic send_length(input logic [31:0] len);
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (shadow_big_end) send_byte(len[8*(HDR_BYTES-1-i) +: 8]);
      else send_byte(len[8*i +: 8]);
    end
  endtask

  task automatic send_frame(input logic [30:0] len);
    send_length({1'b0, len});
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Stop sending, let every expected result drain, then pad for latency
  // (header bytes give no result but may still be in flight).
  task automatic settle();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (frame_results_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY_PAD) @(posedge clk_i);
  endtask

  // Register write; only called with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_MAGIC_WORD:  shadow_magic    = data;
      CFG_MAGIC_EN:    shadow_magic_en = data[0];
      CFG_LEN_BIG_END: shadow_big_end  = data[0];
      CFG_MAX_FRAME:   shadow_max_len  = data[LEN_W-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // The preamble is checked once per reset, so the seed picks one flavor:
  // good preamble (most runs), check switched off mid-preamble, or a bad
  // preamble that halts the block for the rest of the run.
  task automatic test_preamble();
    preamble_mode_e mode;
    logic [31:0]    magic;
    logic [31:0]    sent;
    int unsigned    pick;
    int unsigned    partial;
    pick = $urandom_range(0, 7);
    if (pick == 7) mode = PRE_MISMATCH;
    else if (pick >= 5) mode = PRE_LATE_OFF;
    else mode = PRE_MATCH;

    case ($urandom_range(0, 3))
      0: magic = 32'h0000_0000;
      1: magic = 32'hFFFF_FFFF;
      default: magic = $urandom();
    endcase
    write_reg(CFG_MAGIC_WORD, 32'hFFFF_FFFF);
    write_reg(CFG_MAGIC_WORD, magic);

    sent = magic;
    if (mode == PRE_MISMATCH) sent = magic ^ (32'd1 << $urandom_range(0, 8*PREAMBLE_LEN-1));

    if (mode == PRE_LATE_OFF) begin
      // zero to PREAMBLE_LEN-1 preamble bytes, then the check goes away
      partial = $urandom_range(0, PREAMBLE_LEN - 1);
      repeat (partial) send_byte(8'($urandom_range(0, 255)));
      settle();
      write_reg(CFG_MAGIC_EN, 32'd0);
    end else begin
      for (int i = PREAMBLE_LEN; i > 0; i--) send_byte(sent[8*(i-1) +: 8]);
    end
  endtask

  // Short hand-picked frames: empty frame, payload byte extremes, both
  // byte orders, and the smallest length limit.
  task automatic test_directed_frames();
    settle();
    write_reg(CFG_MAX_FRAME, {1'b0, MAX_FRAME_RST});
    write_reg(CFG_LEN_BIG_END, 32'd1);
    send_length(32'd0);
    send_length(32'd1);
    send_byte(8'hFF);
    settle();
    write_reg(CFG_LEN_BIG_END, 32'd0);
    send_length(32'd2);
    send_byte(8'h00);
    send_byte(8'h80);
    settle();
    write_reg(CFG_MAX_FRAME, 32'd0);
    send_length(32'd0);
  endtask

  // Well-formed frames with random content, in segments that each run
  // under a fresh register setting. One segment runs without any stall.
  task automatic test_random_frames();
    int unsigned goal;
    int unsigned seg_end;
    int unsigned seg;
    logic [30:0] cap;
    logic [30:0] len;
    goal = bytes_sent + RANDOM_BYTES;
    seg  = 0;
    while (bytes_sent < goal) begin
      settle();
      write_reg(CFG_LEN_BIG_END, {31'd0, 1'($urandom_range(0, 1))});
      case ($urandom_range(0, 3))
        0: cap = MAX_FRAME_RST;
        1: cap = 31'($urandom_range(0, 20));
        2: cap = 31'($urandom());
        default: cap = 31'($urandom_range(1, 64));
      endcase
      write_reg(CFG_MAX_FRAME, {1'b0, cap});
      // Past the preamble these two no longer matter; written for coverage
      if ($urandom_range(0, 2) == 0) write_reg(CFG_MAGIC_WORD, $urandom());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_MAGIC_EN, {31'd0, 1'($urandom_range(0, 1))});

      src_idle_pct  = (seg == 2) ? 0 : IDLE_PCT;
      sink_idle_pct = (seg == 2) ? 0 : IDLE_PCT;

      seg_end = bytes_sent + SEG_BYTES;
      while (bytes_sent < seg_end && bytes_sent < goal) begin
        // mostly short frames, now and then a longer one
        if ($urandom_range(0, 9) == 0) len = 31'($urandom_range(0, 64));
        else len = 31'($urandom_range(0, 12));
        if (len > shadow_max_len) len = shadow_max_len;
        send_frame(len);
      end
      seg++;
    end
    src_idle_pct  = IDLE_PCT;
    sink_idle_pct = IDLE_PCT;
  endtask

  // Ends the run: a negative or over-limit length halts the block, and
  // the bytes after it must vanish.
  task automatic test_bad_length();
    logic [31:0] len;
    settle();
    if ($urandom_range(0, 1) == 1) begin
      len = $urandom();
      len[8*HDR_BYTES-1] = 1'b1;
    end else begin
      write_reg(CFG_MAX_FRAME, 32'($urandom_range(0, 1000)));
      len = {1'b0, shadow_max_len} + 32'($urandom_range(1, 100));
    end
    send_length(len);
    repeat (20) send_byte(8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_preamble();
    test_directed_frames();
    test_random_frames();
    test_bad_length();

    settle();
    repeat (LATENCY_PAD) @(posedge clk_i);
    if (frame_results_due.size() != 0) begin
      $error("%0d expected results never arrived", frame_results_due.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
